// ===== rtl/msadpcm_pkg.sv =====
`timescale 1ns / 1ps

package msadpcm_pkg;

  localparam int CHANNELS_DEFAULT = 2;
  localparam int QUEUE_DEPTH      = 2;

  localparam int SAMPLE_W = 16;
  localparam int DELTA_W  = 31;

  localparam logic [32:0] DELTA_MIN = 33'd16;
  localparam logic [32:0] DELTA_MAX = 33'd2147483647;

  // Coefficient pairs; the eighth entry is never loaded and falls back to the first.
  localparam logic signed [10:0] COEF0 [8] =
    '{11'sd256, 11'sd512, 11'sd0, 11'sd192, 11'sd240, 11'sd460, 11'sd392, 11'sd256};
  localparam logic signed [10:0] COEF1 [8] =
    '{11'sd0, -11'sd256, 11'sd0, 11'sd64, 11'sd0, -11'sd208, -11'sd232, 11'sd0};

  localparam logic [9:0] ADAPT [16] =
    '{10'd230, 10'd230, 10'd230, 10'd230, 10'd307, 10'd409, 10'd512, 10'd614,
      10'd768, 10'd614, 10'd512, 10'd409, 10'd307, 10'd230, 10'd230, 10'd230};

  localparam logic [7:0] PAIR_COUNT = 8'd7;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_HDR,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic                         channel;
    logic [2:0]                   coef;
    logic [14:0]                  delta;
    logic signed [SAMPLE_W-1:0]   newer;
    logic signed [SAMPLE_W-1:0]   older;
    logic [3:0]                   nibble;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FIN,
    B_HDR2
  } back_state_t;

endpackage

// ===== rtl/msadpcm_if.sv =====
`timescale 1ns / 1ps

interface msadpcm_item_if import msadpcm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic                       channel;
  logic [7:0]                 pred_index;
  logic signed [SAMPLE_W-1:0] init_delta;
  logic signed [SAMPLE_W-1:0] init_newer;
  logic signed [SAMPLE_W-1:0] init_older;
  logic [3:0]                 nibble;

  modport source (output valid, op, channel, pred_index, init_delta, init_newer,
                  init_older, nibble, input ready);
  modport sink (input valid, op, channel, pred_index, init_delta, init_newer,
                init_older, nibble, output ready);
endinterface

interface msadpcm_result_if import msadpcm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       channel_out;
  logic                       error;
  logic                       last;

  modport source (output valid, sample, channel_out, error, last, input ready);
  modport sink (input valid, sample, channel_out, error, last, output ready);
endinterface

// ===== rtl/msadpcm_front.sv =====
`timescale 1ns / 1ps

module msadpcm_front import msadpcm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  msadpcm_item_if.sink item,
  input  queue_status_t qstat,
  output logic          push,
  output cmd_t          cmd
);

  logic ch_sat;

  // Channels beyond the configured count fold onto the last one.
  assign ch_sat = (32'(item.channel) >= 32'(CHANNELS)) ? 1'(CHANNELS - 1) : item.channel;

  assign item.ready = !qstat.full;
  assign push       = item.valid && !qstat.full;

  always_comb begin
    cmd.channel = ch_sat;
    cmd.coef    = item.pred_index[2:0];
    cmd.delta   = item.init_delta[14:0];
    cmd.newer   = item.init_newer;
    cmd.older   = item.init_older;
    cmd.nibble  = item.nibble;
    if (item.op) begin
      cmd.kind = CMD_DATA;
    end else if (item.pred_index >= PAIR_COUNT || item.init_delta[SAMPLE_W-1]) begin
      cmd.kind = CMD_BAD;
    end else begin
      cmd.kind = CMD_HDR;
    end
  end

endmodule

// ===== rtl/msadpcm_queue.sv =====
`timescale 1ns / 1ps

module msadpcm_queue import msadpcm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t qstat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    if (32'(p) == QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign qstat.full  = (32'(count) == QUEUE_DEPTH);
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/msadpcm_back.sv =====
`timescale 1ns / 1ps

module msadpcm_back import msadpcm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          head,
  input  queue_status_t qstat,
  output logic          pop,
  msadpcm_result_if.source result
);

  // Per-channel decoder state.
  logic [2:0]                 coef_select [CHANNELS];
  logic [DELTA_W-1:0]         step_delta  [CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_newer  [CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_older  [CHANNELS];

  back_state_t state, state_next;

  // Output register.
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_channel;
  logic                       out_error;
  logic                       out_last;

  // Work registers for a data item in flight.
  logic                       ch_q;
  logic signed [26:0]         prod0_q, prod1_q;
  logic signed [35:0]         dprod_q;
  logic [40:0]                aprod_q;
  logic signed [SAMPLE_W-1:0] hold_newer;

  logic can_out;
  logic emit;
  logic signed [SAMPLE_W-1:0] emit_sample;
  logic emit_error, emit_last;
  logic hdr_write, data_write, data_start;

  logic signed [26:0] prod0_d, prod1_d;
  logic signed [35:0] dprod_d;
  logic [40:0]        aprod_d;
  logic signed [27:0] pred_sum;
  logic signed [27:0] pred;
  logic signed [36:0] smp_wide;
  logic signed [SAMPLE_W-1:0] smp_sat;
  logic [32:0]        nd_raw;
  logic [DELTA_W-1:0] nd_clamp;

  assign can_out = !out_valid || result.ready;

  // First half of a data item: four independent products from the stored state.
  always_comb begin
    prod0_d = 27'(hist_newer[head.channel]) * 27'(COEF0[coef_select[head.channel]]);
    prod1_d = 27'(hist_older[head.channel]) * 27'(COEF1[coef_select[head.channel]]);
    dprod_d = 36'($signed(head.nibble)) * 36'($signed({1'b0, step_delta[head.channel]}));
    aprod_d = 41'(step_delta[head.channel]) * 41'(ADAPT[head.nibble]);
  end

  // Second half: prediction, saturation and step adaptation.
  always_comb begin
    pred_sum = 28'(prod0_q) + 28'(prod1_q);
    pred     = pred_sum >>> 8;
    smp_wide = 37'(pred) + 37'(dprod_q);
    if (smp_wide < -37'sd32768) begin
      smp_sat = -16'sd32768;
    end else if (smp_wide > 37'sd32767) begin
      smp_sat = 16'sd32767;
    end else begin
      smp_sat = smp_wide[SAMPLE_W-1:0];
    end
    nd_raw = aprod_q[40:8];
    if (nd_raw < DELTA_MIN) begin
      nd_clamp = DELTA_W'(DELTA_MIN);
    end else if (nd_raw > DELTA_MAX) begin
      nd_clamp = DELTA_W'(DELTA_MAX);
    end else begin
      nd_clamp = nd_raw[DELTA_W-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    emit        = 1'b0;
    emit_sample = '0;
    emit_error  = 1'b0;
    emit_last   = 1'b1;
    hdr_write   = 1'b0;
    data_write  = 1'b0;
    data_start  = 1'b0;
    case (state)
      B_IDLE: begin
        if (!qstat.empty) begin
          case (head.kind)
            CMD_DATA: begin
              pop        = 1'b1;
              data_start = 1'b1;
              state_next = B_FIN;
            end
            CMD_HDR: begin
              if (can_out) begin
                pop         = 1'b1;
                emit        = 1'b1;
                emit_sample = head.older;
                emit_last   = 1'b0;
                hdr_write   = 1'b1;
                state_next  = B_HDR2;
              end
            end
            default: begin
              if (can_out) begin
                pop        = 1'b1;
                emit       = 1'b1;
                emit_error = 1'b1;
              end
            end
          endcase
        end
      end
      B_FIN: begin
        if (can_out) begin
          emit        = 1'b1;
          emit_sample = smp_sat;
          data_write  = 1'b1;
          state_next  = B_IDLE;
        end
      end
      B_HDR2: begin
        if (can_out) begin
          emit        = 1'b1;
          emit_sample = hold_newer;
          state_next  = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample  <= emit_sample;
      out_error   <= emit_error;
      out_last    <= emit_last;
      out_channel <= (state == B_IDLE) ? head.channel : ch_q;
    end
    if (pop) begin
      ch_q <= head.channel;
    end
    if (hdr_write) begin
      hold_newer <= head.newer;
    end
    if (data_start) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
      dprod_q <= dprod_d;
      aprod_q <= aprod_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        coef_select[i] <= '0;
        step_delta[i]  <= '0;
        hist_newer[i]  <= '0;
        hist_older[i]  <= '0;
      end
    end else if (hdr_write) begin
      coef_select[head.channel] <= head.coef;
      step_delta[head.channel]  <= DELTA_W'(head.delta);
      hist_newer[head.channel]  <= head.newer;
      hist_older[head.channel]  <= head.older;
    end else if (data_write) begin
      step_delta[ch_q] <= nd_clamp;
      hist_newer[ch_q] <= smp_sat;
      hist_older[ch_q] <= hist_newer[ch_q];
    end
  end

  assign result.valid       = out_valid;
  assign result.sample      = out_sample;
  assign result.channel_out = out_channel;
  assign result.error       = out_error;
  assign result.last        = out_last;

  // The second half of a header always finds the first result still registered.
  a_hdr2_holds_first: assert property (@(posedge clk) disable iff (rst)
    (state == B_HDR2) |-> (out_valid && !out_last && !out_error))
    else $error("header second phase without a pending first sample");

  // An error result is always the only result of its word.
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error) |-> out_last)
    else $error("error result not marked last");

  // After a data word finishes, the channel's step never falls below the minimum.
  a_delta_floor: assert property (@(posedge clk) disable iff (rst)
    data_write |=> (33'(step_delta[ch_q]) >= DELTA_MIN))
    else $error("adapted step below minimum");

  // A data word is popped only into the finishing phase.
  a_data_to_fin: assert property (@(posedge clk) disable iff (rst)
    data_start |=> (state == B_FIN))
    else $error("data word did not enter the finishing phase");

endmodule

// ===== rtl/ms_adpcm_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel   Role     Word contents
// item      sink     op, channel, pred_index, init_delta, init_newer, init_older, nibble
// result    source   sample, channel_out, error, last
//
// The back end forms a data word's predictor and step products from the channel state,
// then, once the result register is free, sums, saturates and writes the state back.
// A valid header returns its older, then its newer sample; a bad one, one error result.
// Reset is synchronous and clears all channel state to zero and empties the queue.
// The front end keeps accepting words into a two-entry queue while the back end waits
// on a stalled result; the result register frees the back end as soon as it is taken.

module ms_adpcm_decoder_core import msadpcm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input logic clk,
  input logic rst,
  msadpcm_item_if.sink     item,
  msadpcm_result_if.source result
);

  // Queue between the classifying front end and the decoding back end.
  queue_status_t qstat;
  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;

  // The front end sorts each word into data, valid header or bad header and folds
  // out-of-range channels onto the last one.
  msadpcm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .item  (item),
    .qstat (qstat),
    .push  (push),
    .cmd   (push_cmd)
  );

  msadpcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // The back end owns the per-channel state, so words for the same channel are
  // naturally handled in order.
  msadpcm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .result (result)
  );

endmodule
